@@ rtl/bns_pkg.sv @@
// Shared constants, codes and types of the bilinear / nearest image scaler.
`timescale 1ns / 1ps
`default_nettype none
package bns_pkg;

	// frame store geometry and sample size
	localparam int MAX_SRC_WIDTH  = 512;
	localparam int MAX_SRC_HEIGHT = 512;
	localparam int SAMPLE_BITS    = 8;
	localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
	localparam int PIX_BITS       = 3 * SAMPLE_BITS;

	// register and field widths
	localparam int SRC_BITS   = 10;
	localparam int DST_BITS   = 13;
	localparam int COORD_BITS = 12;
	localparam int CFG_BITS   = 13;
	localparam int IDX_BITS   = 3;
	localparam int OUT_BITS   = 8;

	// coordinate divider: quotient up to the source size
	localparam int QB       = SRC_BITS;
	localparam int DNM_BITS = DST_BITS + 1;
	localparam int NUM_BITS = COORD_BITS + 1 + SRC_BITS + 1;

	// blend datapath
	localparam int TOP_BITS = DNM_BITS + SAMPLE_BITS;
	localparam int SUM_BITS = 2 * DNM_BITS + SAMPLE_BITS;
	localparam int DEN_BITS = 2 * DNM_BITS;
	localparam int N2_BITS  = SUM_BITS + 2;
	localparam int D2_BITS  = DEN_BITS + 1;
	localparam int CNT_BITS = 4;

	// configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_SRC_WIDTH     = 3'd0,
		REG_SRC_HEIGHT    = 3'd1,
		REG_DST_WIDTH     = 3'd2,
		REG_DST_HEIGHT    = 3'd3,
		REG_THREE_CHANNEL = 3'd4,
		REG_BILINEAR_MODE = 3'd5
	} reg_idx_t;

	// input item kinds
	localparam logic OP_STORE   = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_ADDR,
		S_READ,
		S_BLEND1,
		S_BLEND2,
		S_RND_LOAD,
		S_RND,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/bns_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bns_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

@@ rtl/bilinear_nearest_image_scaler_unit.sv @@
// Image scaler: frame store, bit-serial coordinate division, four-tap blend and rounding.
// Store beat: written into the frame store at the accepting edge; the unit stays ready for the next beat.
// Request in range: passes through the 10-step coordinate divider, frame store reads on
//   its one port, the blend and the 8-step rounding divider; no new item is taken until
//   the result has moved to the output register, which can stall it.
// Request out of range: goes straight to the done state and returns zeros with out_of_range set.
// Reset loads the register defaults; the frame store is not cleared (garbage until written).
`timescale 1ns / 1ps
`default_nettype none
module bilinear_nearest_image_scaler_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [bns_pkg::IDX_BITS-1:0]  cfg_index,
	input  wire logic [bns_pkg::CFG_BITS-1:0]  cfg_data,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [47:0]                   s_tdata,  // coord_x, coord_y, sample_a, sample_b, sample_c
	input  wire logic                          s_tuser,  // op
	// output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [23:0]                   m_tdata,  // out_a, out_b, out_c
	output logic                               m_tuser   // out_of_range
);

	localparam int SB = bns_pkg::SAMPLE_BITS;

	bns_pkg::state_t state_q, state_d;

	// configuration
	logic [bns_pkg::SRC_BITS-1:0] sw_q, sh_q;
	logic [bns_pkg::DST_BITS-1:0] dw_q, dh_q;
	logic                         three_q, bil_q;

	// current request
	logic [bns_pkg::COORD_BITS-1:0] cx_q, cy_q;
	logic                           oor_q;

	// coordinate dividers, lane 0 columns, lane 1 rows
	logic [bns_pkg::NUM_BITS-1:0] num_q [2];
	logic [bns_pkg::DNM_BITS-1:0] dnm_q [2];
	logic [bns_pkg::DNM_BITS-1:0] r_q   [2];
	logic [bns_pkg::QB-1:0]       n_q   [2];
	logic [bns_pkg::CNT_BITS-1:0] cnt_q;

	// neighbor indexes and weights, [lane][tap]
	logic [bns_pkg::QB-1:0]       idx_q [2][2];
	logic [bns_pkg::DNM_BITS-1:0] w_q   [2][2];
	logic [bns_pkg::DEN_BITS-1:0] den_q;

	// fetched pixels: 00, 10, 01, 11
	logic [bns_pkg::PIX_BITS-1:0] pix_q [4];

	// blend and rounding per channel
	logic [bns_pkg::TOP_BITS-1:0] top_q [3], bot_q [3];
	logic [bns_pkg::SUM_BITS-1:0] sum_q [3];
	logic [bns_pkg::D2_BITS-1:0]  r2_q  [3];
	logic [SB-1:0]                n2_q  [3];

	// output register
	logic                         m_tvalid_q;
	logic [23:0]                  m_tdata_q;
	logic                         m_tuser_q;

	// frame store port
	logic                          ram_we;
	logic [bns_pkg::ADDR_BITS-1:0] ram_addr;
	logic [bns_pkg::PIX_BITS-1:0]  ram_rdata;

	// input fields
	logic                           in_acc;
	logic [bns_pkg::COORD_BITS-1:0] in_x, in_y;
	logic                           in_oor;

	// saturated source size
	logic [bns_pkg::SRC_BITS-1:0] sws, shs;
	logic [bns_pkg::SRC_BITS-1:0] size_l [2];

	logic                         out_free;

	assign in_acc   = s_tvalid && s_tready;
	assign in_x     = s_tdata[11:0];
	assign in_y     = s_tdata[23:12];
	assign in_oor   = ({1'b0, in_x} >= dw_q) || ({1'b0, in_y} >= dh_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// saturate source size into 1..max
	always_comb begin
		if (sw_q == '0) begin
			sws = bns_pkg::SRC_BITS'(1);
		end else if (int'(sw_q) > bns_pkg::MAX_SRC_WIDTH) begin
			sws = bns_pkg::SRC_BITS'(bns_pkg::MAX_SRC_WIDTH);
		end else begin
			sws = sw_q;
		end
		if (sh_q == '0) begin
			shs = bns_pkg::SRC_BITS'(1);
		end else if (int'(sh_q) > bns_pkg::MAX_SRC_HEIGHT) begin
			shs = bns_pkg::SRC_BITS'(bns_pkg::MAX_SRC_HEIGHT);
		end else begin
			shs = sh_q;
		end
		size_l[0] = sws;
		size_l[1] = shs;
	end

	// frame store
	bns_ram #(
		.WIDTH (bns_pkg::PIX_BITS),
		.DEPTH (bns_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (s_tdata[47:24]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bns_pkg::S_IDLE: begin
				if (in_acc && s_tuser == bns_pkg::OP_REQUEST) begin
					state_d = in_oor ? bns_pkg::S_DONE : bns_pkg::S_MUL;
				end
			end
			bns_pkg::S_MUL:  state_d = bns_pkg::S_LOAD;
			bns_pkg::S_LOAD: state_d = bns_pkg::S_DIV;
			bns_pkg::S_DIV: begin
				if (cnt_q == bns_pkg::CNT_BITS'(bns_pkg::QB - 1)) begin
					state_d = bns_pkg::S_ADDR;
				end
			end
			bns_pkg::S_ADDR: state_d = bns_pkg::S_READ;
			bns_pkg::S_READ: begin
				if (cnt_q == bns_pkg::CNT_BITS'(4)) begin
					state_d = bns_pkg::S_BLEND1;
				end
			end
			bns_pkg::S_BLEND1:   state_d = bns_pkg::S_BLEND2;
			bns_pkg::S_BLEND2:   state_d = bns_pkg::S_RND_LOAD;
			bns_pkg::S_RND_LOAD: state_d = bns_pkg::S_RND;
			bns_pkg::S_RND: begin
				if (cnt_q == bns_pkg::CNT_BITS'(SB - 1)) begin
					state_d = bns_pkg::S_DONE;
				end
			end
			bns_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bns_pkg::S_IDLE;
				end
			end
			default: state_d = bns_pkg::S_IDLE;
		endcase
	end

	// handshake and frame store port
	always_comb begin
		logic [bns_pkg::QB-1:0] ax, ay;
		s_tready = (state_q == bns_pkg::S_IDLE);
		ram_we   = in_acc && s_tuser == bns_pkg::OP_STORE
			&& int'(in_x) < bns_pkg::MAX_SRC_WIDTH && int'(in_y) < bns_pkg::MAX_SRC_HEIGHT;
		ax       = cnt_q[0] ? idx_q[0][1] : idx_q[0][0];
		ay       = cnt_q[1] ? idx_q[1][1] : idx_q[1][0];
		if (state_q == bns_pkg::S_READ) begin
			ram_addr = bns_pkg::ADDR_BITS'(int'(ay) * bns_pkg::MAX_SRC_WIDTH + int'(ax));
		end else begin
			ram_addr = bns_pkg::ADDR_BITS'(int'(in_y) * bns_pkg::MAX_SRC_WIDTH + int'(in_x));
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bns_pkg::S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			sw_q       <= bns_pkg::SRC_BITS'(512);
			sh_q       <= bns_pkg::SRC_BITS'(512);
			dw_q       <= bns_pkg::DST_BITS'(512);
			dh_q       <= bns_pkg::DST_BITS'(512);
			three_q    <= 1'b1;
			bil_q      <= 1'b1;
		end else begin
			state_q <= state_d;
			// step counter for dividers and reads
			case (state_q)
				bns_pkg::S_DIV, bns_pkg::S_READ, bns_pkg::S_RND: begin
					cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
				end
				default: cnt_q <= '0;
			endcase
			if (state_q == bns_pkg::S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					bns_pkg::REG_SRC_WIDTH:     sw_q    <= cfg_data[bns_pkg::SRC_BITS-1:0];
					bns_pkg::REG_SRC_HEIGHT:    sh_q    <= cfg_data[bns_pkg::SRC_BITS-1:0];
					bns_pkg::REG_DST_WIDTH:     dw_q    <= cfg_data[bns_pkg::DST_BITS-1:0];
					bns_pkg::REG_DST_HEIGHT:    dh_q    <= cfg_data[bns_pkg::DST_BITS-1:0];
					bns_pkg::REG_THREE_CHANNEL: three_q <= cfg_data[0];
					bns_pkg::REG_BILINEAR_MODE: bil_q   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic [bns_pkg::DNM_BITS:0]   t;
		logic [bns_pkg::D2_BITS:0]    t2;
		logic [bns_pkg::N2_BITS-1:0]  num2;
		logic [bns_pkg::QB-1:0]       q;
		logic [bns_pkg::QB-1:0]       s;
		logic [bns_pkg::COORD_BITS:0] pos [2];
		logic [SB-1:0]                p   [4];
		case (state_q)
			bns_pkg::S_IDLE: begin
				if (in_acc) begin
					cx_q  <= in_x;
					cy_q  <= in_y;
					oor_q <= in_oor;
				end
			end
			// numerators: nearest 2*d*s + dd, bilinear (2*d+1)*s + dd (floor offset by one)
			bns_pkg::S_MUL: begin
				pos[0]   = {cx_q, bil_q};
				pos[1]   = {cy_q, bil_q};
				num_q[0] <= bns_pkg::NUM_BITS'(pos[0]) * bns_pkg::NUM_BITS'(sws)
					+ bns_pkg::NUM_BITS'(dw_q);
				num_q[1] <= bns_pkg::NUM_BITS'(pos[1]) * bns_pkg::NUM_BITS'(shs)
					+ bns_pkg::NUM_BITS'(dh_q);
				dnm_q[0] <= {dw_q, 1'b0};
				dnm_q[1] <= {dh_q, 1'b0};
				den_q    <= bns_pkg::DEN_BITS'({dw_q, 1'b0}) * bns_pkg::DEN_BITS'({dh_q, 1'b0});
			end
			bns_pkg::S_LOAD: begin
				for (int l = 0; l < 2; l++) begin
					r_q[l] <= bns_pkg::DNM_BITS'(num_q[l] >> bns_pkg::QB);
					n_q[l] <= num_q[l][bns_pkg::QB-1:0];
				end
			end
			// one quotient bit per cycle in each lane
			bns_pkg::S_DIV: begin
				for (int l = 0; l < 2; l++) begin
					t = {r_q[l], n_q[l][bns_pkg::QB-1]};
					if (t >= {1'b0, dnm_q[l]}) begin
						r_q[l] <= bns_pkg::DNM_BITS'(t - {1'b0, dnm_q[l]});
						n_q[l] <= {n_q[l][bns_pkg::QB-2:0], 1'b1};
					end else begin
						r_q[l] <= t[bns_pkg::DNM_BITS-1:0];
						n_q[l] <= {n_q[l][bns_pkg::QB-2:0], 1'b0};
					end
				end
			end
			// clamp neighbors, pick weights
			bns_pkg::S_ADDR: begin
				for (int l = 0; l < 2; l++) begin
					q = n_q[l];
					s = size_l[l];
					if (bil_q) begin
						idx_q[l][0] <= (q == '0) ? '0 : q - 1'b1;
						idx_q[l][1] <= (q >= s) ? s - 1'b1 : q;
						w_q[l][0]   <= dnm_q[l] - r_q[l];
						w_q[l][1]   <= r_q[l];
					end else begin
						idx_q[l][0] <= (q >= s) ? s - 1'b1 : q;
						idx_q[l][1] <= (q >= s) ? s - 1'b1 : q;
						w_q[l][0]   <= dnm_q[l];
						w_q[l][1]   <= '0;
					end
				end
			end
			// read data arrives in the cycle after its address
			bns_pkg::S_READ: begin
				if (cnt_q != '0) begin
					pix_q[2'(cnt_q - 1'b1)] <= ram_rdata;
				end
			end
			bns_pkg::S_BLEND1: begin
				for (int c = 0; c < 3; c++) begin
					for (int k = 0; k < 4; k++) begin
						p[k] = pix_q[k][c*SB +: SB];
					end
					top_q[c] <= bns_pkg::TOP_BITS'(w_q[0][0]) * bns_pkg::TOP_BITS'(p[0])
						+ bns_pkg::TOP_BITS'(w_q[0][1]) * bns_pkg::TOP_BITS'(p[1]);
					bot_q[c] <= bns_pkg::TOP_BITS'(w_q[0][0]) * bns_pkg::TOP_BITS'(p[2])
						+ bns_pkg::TOP_BITS'(w_q[0][1]) * bns_pkg::TOP_BITS'(p[3]);
				end
			end
			bns_pkg::S_BLEND2: begin
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= bns_pkg::SUM_BITS'(w_q[1][0]) * bns_pkg::SUM_BITS'(top_q[c])
						+ bns_pkg::SUM_BITS'(w_q[1][1]) * bns_pkg::SUM_BITS'(bot_q[c]);
				end
			end
			// round half up: (2*sum + den) / (2*den)
			bns_pkg::S_RND_LOAD: begin
				for (int c = 0; c < 3; c++) begin
					num2     = {1'b0, sum_q[c], 1'b0} + bns_pkg::N2_BITS'(den_q);
					r2_q[c] <= bns_pkg::D2_BITS'(num2 >> SB);
					n2_q[c] <= num2[SB-1:0];
				end
			end
			bns_pkg::S_RND: begin
				for (int c = 0; c < 3; c++) begin
					t2 = {r2_q[c], n2_q[c][SB-1]};
					if (t2 >= {1'b0, den_q, 1'b0}) begin
						r2_q[c] <= bns_pkg::D2_BITS'(t2 - {1'b0, den_q, 1'b0});
						n2_q[c] <= {n2_q[c][SB-2:0], 1'b1};
					end else begin
						r2_q[c] <= t2[bns_pkg::D2_BITS-1:0];
						n2_q[c] <= {n2_q[c][SB-2:0], 1'b0};
					end
				end
			end
			bns_pkg::S_DONE: begin
				if (out_free) begin
					m_tuser_q <= oor_q;
					if (oor_q) begin
						m_tdata_q <= '0;
					end else begin
						m_tdata_q[7:0]   <= bns_pkg::OUT_BITS'(n2_q[0]);
						m_tdata_q[15:8]  <= three_q ? bns_pkg::OUT_BITS'(n2_q[1]) : '0;
						m_tdata_q[23:16] <= three_q ? bns_pkg::OUT_BITS'(n2_q[2]) : '0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
